@@ sv/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int VALUE_W             = 32;
    localparam int PRIO_W              = 16;
    localparam int STATUS_W            = 2;

    // Operation codes carried on the op field.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD_NEW   = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      occupied;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
`default_nettype none

// Sorted priority queue of QUEUE_DEPTH entries built as a chain of cells, the
// head in cell 0. Each input beat is an enqueue (value and priority) or a
// dequeue. Entries stay ordered by ascending signed priority; an entry is placed
// after every held entry of equal priority, so ties leave in arrival order. All
// cells compare the incoming priority with their own in parallel and, in the
// same cycle, either hold, load the new entry, or take their neighbor's entry,
// so one beat is accepted every clock cycle. Each beat yields exactly one result
// beat, registered, in the cycle after acceptance; the output register decouples
// the two sides, and a new beat is taken whenever the result register is empty
// or is being drained in the same cycle. A dequeue on an empty queue returns
// status 1 and an enqueue on a full queue returns status 2, leaving the queue
// unchanged; out_value and out_priority are zero unless a dequeue succeeds.
// occupancy reports the entry count after the operation.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire                      op,
    input  wire logic [VALUE_W-1:0]  item_value,
    input  wire logic [PRIO_W-1:0]   item_priority,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic      [STATUS_W-1:0] status,
    output logic      [VALUE_W-1:0]  out_value,
    output logic      [PRIO_W-1:0]   out_priority,
    output logic      [CNT_W-1:0]    occupancy
);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [VALUE_W-1:0]  out_value_next;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [PRIO_W-1:0]   out_prio_next;

    logic in_fire;
    logic is_empty;
    logic is_full;
    logic do_enq;
    logic do_deq;

    logic [VALUE_W-1:0] cell_value [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  cell_prio  [QUEUE_DEPTH];
    logic               cell_place [QUEUE_DEPTH];
    cell_ctrl_t         cell_ctrl  [QUEUE_DEPTH];

    // A new beat may enter when the result register is free or drains now.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_enq   = in_fire && (op == OP_ENQUEUE) && !is_full;
    assign do_deq   = in_fire && (op == OP_DEQUEUE) && !is_empty;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic               left_place;
            logic [VALUE_W-1:0] left_value;
            logic [PRIO_W-1:0]  left_prio;
            logic [VALUE_W-1:0] right_value;
            logic [PRIO_W-1:0]  right_prio;

            // The head has no left neighbor; the new entry can always land there.
            if (i == 0)
            begin : g_head
                assign left_place = 1'b0;
                assign left_value = item_value;
                assign left_prio  = item_priority;
            end
            else
            begin : g_body
                assign left_place = cell_place[i-1];
                assign left_value = cell_value[i-1];
                assign left_prio  = cell_prio[i-1];
            end

            // The tail takes its own contents on a dequeue; it falls out of use.
            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_value = cell_value[i];
                assign right_prio  = cell_prio[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
                assign right_prio  = cell_prio[i+1];
            end

            // On a dequeue every cell takes its right neighbor's entry. On an enqueue the first
            // cell flagging a place takes the new entry, every cell after it shifts one slot toward the tail.
            always_comb
            begin
                cell_ctrl[i].occupied = (CNT_W'(i) < count_reg);
                if (do_deq)
                    cell_ctrl[i].sel = CELL_FROM_RIGHT;
                else if (do_enq && cell_place[i] && !left_place)
                    cell_ctrl[i].sel = CELL_LOAD_NEW;
                else if (do_enq && cell_place[i])
                    cell_ctrl[i].sel = CELL_FROM_LEFT;
                else
                    cell_ctrl[i].sel = CELL_HOLD;
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[i]),
                .new_value   (item_value),
                .new_prio    (item_priority),
                .left_value  (left_value),
                .left_prio   (left_prio),
                .right_value (right_value),
                .right_prio  (right_prio),
                .value       (cell_value[i]),
                .prio        (cell_prio[i]),
                .place       (cell_place[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
            count_next = count_reg + CNT_W'(1);
        else if (do_deq)
            count_next = count_reg - CNT_W'(1);
    end

    // Result of the accepted beat, computed from the state it saw.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_prio_next   = out_prio_reg;
        if (in_fire)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_value_next  = '0;
            out_prio_next   = '0;
            if (op == OP_DEQUEUE)
            begin
                if (is_empty)
                    out_status_next = STATUS_EMPTY;
                else
                begin
                    out_value_next = cell_value[0];
                    out_prio_next  = cell_prio[0];
                end
            end
            else if (is_full)
                out_status_next = STATUS_FULL;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    logic [CNT_W-1:0] out_occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_prio_reg   <= out_prio_next;
        if (in_fire)
            out_occ_reg <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = out_occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op == OP_ENQUEUE) && !is_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("successful enqueue did not add one entry");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op == OP_DEQUEUE) && is_empty)
        |=> (out_valid_reg && (out_status_reg == STATUS_EMPTY) && (count_reg == '0)))
        else $error("dequeue on empty queue mishandled");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> ($signed(cell_prio[0]) <= $signed(cell_prio[1])))
        else $error("head entries out of priority order");
`endif

endmodule

`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none

// One slot of the sorted chain. It flags whether a new entry belongs at or
// before this slot, and loads from the new entry or from either neighbor.
module spq_cell
    import spq_pkg::*;
(
    input  wire                      clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [VALUE_W-1:0]  new_value,
    input  wire logic [PRIO_W-1:0]   new_prio,
    input  wire logic [VALUE_W-1:0]  left_value,
    input  wire logic [PRIO_W-1:0]   left_prio,
    input  wire logic [VALUE_W-1:0]  right_value,
    input  wire logic [PRIO_W-1:0]   right_prio,
    output logic      [VALUE_W-1:0]  value,
    output logic      [PRIO_W-1:0]   prio,
    output logic                     place
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [PRIO_W-1:0]  prio_reg;
    logic [PRIO_W-1:0]  prio_next;

    // An empty slot, or one holding a strictly larger priority number,
    // lies at or after the insertion point.
    assign place = !ctrl.occupied || ($signed(prio_reg) > $signed(new_prio));

    always_comb
    begin
        case (ctrl.sel)
            CELL_LOAD_NEW:
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            CELL_FROM_LEFT:
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
            CELL_FROM_RIGHT:
            begin
                value_next = right_value;
                prio_next  = right_prio;
            end
            default:
            begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

@@ tb/sv/spq_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the priority queue, keeps its own sorted copy of the
// entries, and compares every result beat with the oldest predicted one.
module spq_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_ready,
    input  wire                 op,
    input  wire [VALUE_W-1:0]   item_value,
    input  wire [PRIO_W-1:0]    item_priority,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  wire [STATUS_W-1:0]  status,
    input  wire [VALUE_W-1:0]   out_value,
    input  wire [PRIO_W-1:0]    out_priority,
    input  wire [CNT_W-1:0]     occupancy,
    output int                  mismatch_count,
    output int                  pending_beats
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
        logic [CNT_W-1:0]    occ;
    } queue_result_t;

    logic [VALUE_W-1:0]       held_values [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] held_prios  [QUEUE_DEPTH];
    int                       held_count;
    queue_result_t            predicted_results[$];

    initial begin
        held_count     = 0;
        mismatch_count = 0;
        pending_beats  = 0;
    end

    // Applies one request to the shadow queue and returns the result it must give.
    function automatic queue_result_t apply_queue_op(
        input logic                     is_dequeue,
        input logic [VALUE_W-1:0]       val,
        input logic signed [PRIO_W-1:0] pri
    );
        queue_result_t res;
        int            pos;
        res        = '0;
        res.status = STATUS_OK;
        if (is_dequeue == OP_DEQUEUE) begin
            if (held_count == 0) begin
                res.status = STATUS_EMPTY;
            end
            else begin
                res.value = held_values[0];
                res.prio  = held_prios[0];
                for (int i = 1; i < held_count; i++) begin
                    held_values[i-1] = held_values[i];
                    held_prios[i-1]  = held_prios[i];
                end
                held_count--;
            end
        end
        else if (held_count >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
        end
        else begin
            // A new entry lands behind every entry of equal or lower priority number.
            pos = 0;
            while (pos < held_count && held_prios[pos] <= pri)
                pos++;
            for (int i = held_count; i > pos; i--) begin
                held_values[i] = held_values[i-1];
                held_prios[i]  = held_prios[i-1];
            end
            held_values[pos] = val;
            held_prios[pos]  = pri;
            held_count++;
        end
        res.occ = held_count[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk) begin : watch_channels
        queue_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result beat arrived with no request outstanding");
                    mismatch_count++;
                end
                else begin
                    want = predicted_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (out_value !== want.value) begin
                        $error("out_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(out_value));
                        mismatch_count++;
                    end
                    if (out_priority !== want.prio) begin
                        $error("out_priority: expected %0d, actual %0d",
                               $signed(want.prio), $signed(out_priority));
                        mismatch_count++;
                    end
                    if (occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_results.push_back(apply_queue_op(op, item_value, item_priority));
            pending_beats = predicted_results.size();
        end
    end

endmodule

@@ tb/sv/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted priority queue. The checker beside the
// block does all prediction and comparison; this module only produces request
// beats, throttles the result side, and reports the outcome at the end.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_BEATS = 850;
    localparam int DRAIN_LIMIT  = 5000;

    // Phases of the random part: each one leans toward a different queue level.
    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} fill_mode_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                op            = OP_ENQUEUE;
    logic [VALUE_W-1:0]  item_value    = '0;
    logic [PRIO_W-1:0]   item_priority = '0;
    logic                out_ready     = 1'b0;
    logic                steady        = 1'b0;

    wire                 in_ready;
    wire                 out_valid;
    wire [STATUS_W-1:0]  status;
    wire [VALUE_W-1:0]   out_value;
    wire [PRIO_W-1:0]    out_priority;
    wire [CNT_W-1:0]     occupancy;
    int                  mismatch_count;
    int                  pending_beats;

    sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .occupancy     (occupancy)
    );

    spq_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .item_value     (item_value),
        .item_priority  (item_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .out_value      (out_value),
        .out_priority   (out_priority),
        .occupancy      (occupancy),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The result side stalls about 29 percent of the time, except while the
    // stimulus runs its steady stretch, where it always takes the beat.
    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 29);
    end

    // Presents one request beat and returns at the edge that accepts it. Random
    // idle cycles come first unless the steady stretch is on. Readiness is
    // looked at on the falling edge, where everything has settled, so the
    // following rising edge is the one that takes the beat.
    task automatic send_beat(
        input logic               beat_op,
        input logic [VALUE_W-1:0] val,
        input logic [PRIO_W-1:0]  pri
    );
        while (!steady && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= beat_op;
        item_value    <= val;
        item_priority <= pri;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Holds the request side quiet until every predicted result has come back,
    // giving up after a bounded number of cycles so a hang still ends the run.
    task automatic wait_for_results();
        int waited;
        waited   = 0;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_beats != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        @(posedge clk);
    endtask

    initial begin : stimulus
        fill_mode_t         mode;
        int                 enq_pct;
        logic               beat_op;
        logic [VALUE_W-1:0] val;
        logic [PRIO_W-1:0]  pri;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A dequeue on the empty queue comes first; then the
        // queue is filled with the extreme values and priorities, with several
        // ties on the lowest, zero and highest priorities to check that equal
        // priorities leave in arrival order.
        send_beat(OP_DEQUEUE, 32'h0000_0000, 16'h0000);
        send_beat(OP_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
        send_beat(OP_ENQUEUE, 32'h8000_0000, 16'h8000);
        send_beat(OP_ENQUEUE, 32'h0000_0000, 16'h0000);
        send_beat(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(OP_ENQUEUE, 32'h0000_0001, 16'h0000);
        send_beat(OP_ENQUEUE, 32'h0000_0002, 16'h0000);
        send_beat(OP_ENQUEUE, 32'h0000_0003, 16'h8000);
        send_beat(OP_ENQUEUE, 32'h0000_0004, 16'h7FFF);
        send_beat(OP_ENQUEUE, 32'h0000_0005, 16'd100);
        send_beat(OP_ENQUEUE, 32'h0000_0006, -16'sd100);
        send_beat(OP_ENQUEUE, 32'h0000_0007, 16'd1);
        send_beat(OP_ENQUEUE, 32'h0000_0008, 16'd1);
        send_beat(OP_ENQUEUE, 32'h0000_0009, 16'h8001);
        send_beat(OP_ENQUEUE, 32'h0000_000A, 16'h7FFE);
        send_beat(OP_ENQUEUE, 32'h0000_000B, 16'd1);
        send_beat(OP_ENQUEUE, 32'h0000_000C, 16'hFFFF);
        // The queue now holds all sixteen entries, so this one must be refused.
        send_beat(OP_ENQUEUE, 32'hA5A5_5A5A, 16'h1234);
        repeat (4)
            send_beat(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(OP_ENQUEUE, 32'h5A5A_A5A5, 16'h0000);
        wait_for_results();

        // Random part. Every forty beats a new phase picks whether the queue is
        // pushed toward full, toward empty, or kept around its middle, so both
        // refusal cases occur often and the shifting paths see every depth.
        mode    = MODE_MIX;
        enq_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0) begin
                mode = fill_mode_t'($urandom_range(0, 2));
                case (mode)
                    MODE_FILL:  enq_pct = 85;
                    MODE_DRAIN: enq_pct = 15;
                    default:    enq_pct = 50;
                endcase
            end
            // A long stretch with no idling on either side.
            if (n == 400)
                steady <= 1'b1;
            if (n == 560)
                steady <= 1'b0;
            // Twice the sender stops until every result is back.
            if (n == 250 || n == 700)
                wait_for_results();

            beat_op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            case ($urandom_range(0, 7))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                default: val = $urandom;
            endcase
            // Narrow priorities give plenty of ties; the rest span the full range.
            case ($urandom_range(0, 3))
                0: pri = PRIO_W'($signed($urandom_range(0, 4)) - 2);
                1: begin
                    case ($urandom_range(0, 3))
                        0:       pri = 16'h8000;
                        1:       pri = 16'h7FFF;
                        2:       pri = 16'hFFFF;
                        default: pri = 16'h0000;
                    endcase
                end
                default: pri = PRIO_W'($urandom);
            endcase
            send_beat(beat_op, val, pri);
        end

        // Let the last results come home, then keep watching for any stray beat the
        // block might still put out before the verdict is reported.
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Ends a run that hangs; the slowest correct run needs far fewer cycles.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
